>>> rtl/vssm_pkg.sv
// Shared types and constants for the version slot state manager.
// Used by the controller, the datapath and the top level; no dependencies.
package vssm_pkg;

   // Pool geometry.
   localparam int SLOTS = 64;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Field widths.
   localparam int ADDR_W  = 48;
   localparam int SHIFT_W = 5;

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd6;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_BASE_ADDRESS = 1'b0,
      CSR_SLOT_SHIFT   = 1'b1
   } csr_index_type;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_ALLOCATE = 2'd0,
      KIND_FREE     = 2'd1,
      KIND_BACKUP   = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   // Slot states.
   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_INUSE = 2'd1,
      ST_SHORT = 2'd2,
      ST_LONG  = 2'd3
   } slot_state_type;

   // Response status codes.
   typedef enum logic [2:0] {
      RES_OK      = 3'd0,
      RES_NOFREE  = 3'd1,
      RES_BADADDR = 3'd2,
      RES_NOTIN   = 3'd3,
      RES_BADTGT  = 3'd4
   } status_type;

   // Controller sequence.
   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_DECODE = 2'd1,
      FSM_CHECK  = 2'd2,
      FSM_COMMIT = 2'd3
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic decode;
      logic check;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> rtl/vssm_ctrl.sv
// Sequencing state machine of the version slot state manager.
// Depends on vssm_pkg for the state, command and status types.
module vssm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vssm_pkg::dp_status_type status,
   output vssm_pkg::ctrl_cmd_type  cmd
);
   import vssm_pkg::*;

   fsm_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands. The commit waits while the result register
   // still holds a beat that the receiver has stalled.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = FSM_DECODE;
            end
         end
         FSM_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = FSM_CHECK;
         end
         FSM_CHECK: begin
            cmd.check = 1'b1;
            state_in  = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            if (!status.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/vssm_datapath.sv
// Datapath of the version slot state manager: slot state flops, free slot
// encoder, address mapping, configuration registers and the result register.
// Depends on vssm_pkg for widths, codes and the command/status types.
module vssm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  vssm_pkg::ctrl_cmd_type               cmd,
   output vssm_pkg::dp_status_type              status,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_index,
   input  logic [vssm_pkg::ADDR_W-1:0]         csr_wdata,
   input  logic [1:0]                          req_kind,
   input  logic [vssm_pkg::ADDR_W-1:0]         req_slot_addr,
   input  logic [1:0]                          req_which_state,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic [vssm_pkg::ADDR_W-1:0]         rsp_slot_address
);
   import vssm_pkg::*;

   // Configuration registers.
   logic [ADDR_W-1:0]  base_ff;
   logic [SHIFT_W-1:0] shift_ff;

   // Captured request.
   kind_type          kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   slot_state_type    which_ff;

   // Decode stage results.
   logic [ADDR_W-1:0] off_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  enc_idx_ff;

   // Check stage results.
   logic              addr_ok_ff;
   logic [IDX_W-1:0]  slot_idx_ff;
   logic [ADDR_W-1:0] alloc_addr_ff;

   // Slot states.
   slot_state_type slot_ff [SLOTS];

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;

   // Combinational signals.
   logic              enc_found;
   logic [IDX_W-1:0]  enc_idx;
   logic [ADDR_W-1:0] low_mask;
   logic [ADDR_W-1:0] idx_full;
   logic              addr_ok;
   slot_state_type    cur_state;
   status_type        commit_status;
   logic [ADDR_W-1:0] commit_addr;
   logic              slot_we;
   slot_state_type    slot_wstate;
   logic              clear_all;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         shift_ff <= SHIFT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_ADDRESS: base_ff  <= csr_wdata;
            CSR_SLOT_SHIFT:   shift_ff <= csr_wdata[SHIFT_W-1:0];
            default:          base_ff  <= base_ff;
         endcase
      end
   end

   // Capture the accepted request beat.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_type'(req_kind);
         addr_ff  <= req_slot_addr;
         which_ff <= slot_state_type'(req_which_state);
      end
   end

   // Priority encoder: lowest numbered free slot.
   always_comb begin
      enc_found = 1'b0;
      enc_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_ff[i] == ST_FREE) begin
            enc_found = 1'b1;
            enc_idx   = IDX_W'(i);
         end
      end
   end

   // Decode stage: offset from the base and the free slot search.
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         off_ff     <= addr_ff - base_ff;
         found_ff   <= enc_found;
         enc_idx_ff <= enc_idx;
      end
   end

   // Address check: the offset must be slot aligned and inside the pool.
   assign low_mask = (ADDR_W'(1) << shift_ff) - ADDR_W'(1);
   assign idx_full = off_ff >> shift_ff;
   assign addr_ok  = ((off_ff & low_mask) == '0) && (idx_full < ADDR_W'(SLOTS));

   // Check stage: slot index and the address of an allocated slot.
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         addr_ok_ff    <= addr_ok;
         slot_idx_ff   <= (kind_ff == KIND_ALLOCATE) ? enc_idx_ff : idx_full[IDX_W-1:0];
         alloc_addr_ff <= base_ff + (ADDR_W'(enc_idx_ff) << shift_ff);
      end
   end

   assign cur_state = slot_ff[slot_idx_ff];

   // Commit decision: status, returned address and the state change.
   always_comb begin
      commit_status = RES_OK;
      commit_addr   = '0;
      slot_we       = 1'b0;
      slot_wstate   = ST_FREE;
      clear_all     = 1'b0;
      unique case (kind_ff)
         KIND_ALLOCATE: begin
            if (found_ff) begin
               commit_addr = alloc_addr_ff;
               slot_we     = 1'b1;
               slot_wstate = ST_INUSE;
            end else begin
               commit_status = RES_NOFREE;
            end
         end
         KIND_FREE: begin
            if (!addr_ok_ff) begin
               commit_status = RES_BADADDR;
            end else if (cur_state != which_ff) begin
               commit_status = RES_NOTIN;
            end else begin
               slot_we     = 1'b1;
               slot_wstate = ST_FREE;
            end
         end
         KIND_BACKUP: begin
            if (!addr_ok_ff) begin
               commit_status = RES_BADADDR;
            end else if (which_ff != ST_SHORT && which_ff != ST_LONG) begin
               commit_status = RES_BADTGT;
            end else if (cur_state != ST_INUSE) begin
               commit_status = RES_NOTIN;
            end else begin
               slot_we     = 1'b1;
               slot_wstate = which_ff;
            end
         end
         KIND_CLEAR: begin
            clear_all = 1'b1;
         end
         default: begin
            commit_status = RES_OK;
         end
      endcase
   end

   // Slot state flops; reset frees every slot at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= ST_FREE;
         end
      end else if (cmd.commit) begin
         if (clear_all) begin
            for (int i = 0; i < SLOTS; i++) begin
               case (slot_ff[i])
                  ST_SHORT: slot_ff[i] <= ST_FREE;
                  ST_LONG:  slot_ff[i] <= ST_SHORT;
                  default:  slot_ff[i] <= slot_ff[i];
               endcase
            end
         end else if (slot_we) begin
            slot_ff[slot_idx_ff] <= slot_wstate;
         end
      end
   end

   // Result register: holds a beat until the receiver takes it.
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= commit_status;
         rsp_addr_ff   <= commit_addr;
      end
   end

   assign status.rsp_busy  = rsp_valid_ff & rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_address = rsp_addr_ff;

endmodule

>>> rtl/version_slot_state_manager.sv
// Version slot state manager: a pool of free, in-use, short and long backup slots,
// with allocate, free, backup and clear requests. Uses vssm_pkg, vssm_ctrl, vssm_datapath.
// A taken request beat is captured, then passes the decode, check and commit steps;
// the result beat is registered at the commit. No new request is taken before the commit,
// and a stalled result beat holds the commit. Synchronous reset frees every slot at once
// and sets base_address to 0 and slot_shift to 6.
module version_slot_state_manager (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [vssm_pkg::ADDR_W-1:0] csr_wdata,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [vssm_pkg::ADDR_W-1:0] req_slot_addr,
   input  logic [1:0]                  req_which_state,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [vssm_pkg::ADDR_W-1:0] rsp_slot_address
);
   import vssm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Controller.
   vssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // Datapath.
   vssm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (dp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_slot_addr    (req_slot_addr),
      .req_which_state  (req_which_state),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_address (rsp_slot_address)
   );

endmodule
